// ----- rtl/hmra_pkg.sv -----
// Shared types and constants for the HID motion report arbiter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hmra_pkg;

  localparam int unsigned DELTA_W   = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MAX_SLOTS = 6;
  localparam int unsigned KEYS_W    = MAX_SLOTS * BYTE_W;

  // Largest magnitude a report axis may carry.
  localparam logic signed [BYTE_W-1:0] REPORT_MAX = 8'sd127;
  localparam logic signed [BYTE_W-1:0] REPORT_MIN = -8'sd127;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_KEYBOARD = 2'd1,
    KIND_MOUSE    = 2'd2
  } hmra_kind_e;

  // One classified tick, handed from the front end to the back end.
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [DELTA_W-1:0] delta_wheel;
    logic [BYTE_W-1:0]         buttons;
    logic                      host_ready;
    logic                      kbd_send;
    logic [BYTE_W-1:0]         modifiers;
    logic [KEYS_W-1:0]         keys;
  } hmra_entry_t;

  // One result transaction as presented at the output.
  typedef struct packed {
    hmra_kind_e               kind;
    logic                     accepted;
    logic [BYTE_W-1:0]        modifiers;
    logic [KEYS_W-1:0]        keys;
    logic [BYTE_W-1:0]        buttons;
    logic signed [BYTE_W-1:0] dx;
    logic signed [BYTE_W-1:0] dy;
    logic signed [BYTE_W-1:0] wheel;
  } hmra_result_t;

endpackage

// ----- rtl/hmra_front.sv -----
// Front end: accepts ticks, tracks keyboard state and decides keyboard reports.
// Depends on hmra_pkg.
`timescale 1ns / 1ps

module hmra_front import hmra_pkg::*; #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      full_i,
  input  logic signed [DELTA_W-1:0] delta_x_i,
  input  logic signed [DELTA_W-1:0] delta_y_i,
  input  logic signed [DELTA_W-1:0] delta_wheel_i,
  input  logic [BYTE_W-1:0]         buttons_i,
  input  logic [BYTE_W-1:0]         modifiers_i,
  input  logic [KEYS_W-1:0]         keys_i,
  input  logic                      host_ready_i,
  output logic                      push_o,
  output hmra_entry_t               entry_o
);

  logic [BYTE_W-1:0] held_mods_q, held_mods_d;
  logic [BYTE_W-1:0] held_keys_q [KEY_SLOTS];
  logic [BYTE_W-1:0] held_keys_d [KEY_SLOTS];
  logic              dirty_q, dirty_d;
  logic              changed;
  logic              dirty_pre;
  logic [KEYS_W-1:0] packed_keys;

  assign push_o = in_valid_i && !full_i;

  always_comb begin
    changed = (modifiers_i != held_mods_q);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (keys_i[BYTE_W*i +: BYTE_W] != held_keys_q[i]) changed = 1'b1;
    end

    held_mods_d = changed ? modifiers_i : held_mods_q;
    packed_keys = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      held_keys_d[i] = changed ? keys_i[BYTE_W*i +: BYTE_W] : held_keys_q[i];
      packed_keys[BYTE_W*i +: BYTE_W] = held_keys_d[i];
    end

    // A ready host drains the dirty mark with a keyboard report.
    dirty_pre = dirty_q || changed;
    dirty_d   = dirty_pre && !host_ready_i;

    entry_o.delta_x     = delta_x_i;
    entry_o.delta_y     = delta_y_i;
    entry_o.delta_wheel = delta_wheel_i;
    entry_o.buttons     = buttons_i;
    entry_o.host_ready  = host_ready_i;
    entry_o.kbd_send    = host_ready_i && dirty_pre;
    entry_o.modifiers   = held_mods_d;
    entry_o.keys        = packed_keys;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mods_q <= '0;
      dirty_q     <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) held_keys_q[i] <= '0;
    end else if (push_o) begin
      held_mods_q <= held_mods_d;
      dirty_q     <= dirty_d;
      for (int i = 0; i < KEY_SLOTS; i++) held_keys_q[i] <= held_keys_d[i];
    end
  end

  a_ready_clears_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && host_ready_i) |=> !dirty_q)
    else $error("keyboard dirty mark survived a ready tick");

endmodule

// ----- rtl/hmra_fifo.sv -----
// Short queue between the front end and the back end.
// Depends on hmra_pkg for the entry type.
`timescale 1ns / 1ps

module hmra_fifo import hmra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  hmra_entry_t entry_i,
  input  logic        pop_i,
  output logic        full_o,
  output logic        empty_o,
  output hmra_entry_t entry_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  hmra_entry_t       slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign entry_o = slots_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= PtrW'((wr_ptr_q + 1'b1) % Depth);
      if (pop_i)  rd_ptr_q <= PtrW'((rd_ptr_q + 1'b1) % Depth);
      count_q <= count_d;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue holds more entries than its depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

endmodule

// ----- rtl/hmra_back.sv -----
// Back end: motion accumulators, mouse report decision and the output register.
// Depends on hmra_pkg.
`timescale 1ns / 1ps

module hmra_back import hmra_pkg::*; #(
  parameter int unsigned ACC_WIDTH = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         empty_i,
  input  hmra_entry_t  entry_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output hmra_result_t result_o
);

  localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_WIDTH-1:0] ClampHi = ACC_WIDTH'(REPORT_MAX);
  localparam logic signed [ACC_WIDTH-1:0] ClampLo = -ClampHi;

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] acc,
    input logic signed [DELTA_W-1:0]   delta
  );
    logic signed [ACC_WIDTH:0] sum;
    sum = {acc[ACC_WIDTH-1], acc} + {{(ACC_WIDTH+1-DELTA_W){delta[DELTA_W-1]}}, delta};
    if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) return sum[ACC_WIDTH] ? AccMin : AccMax;
    return sum[ACC_WIDTH-1:0];
  endfunction

  function automatic logic signed [BYTE_W-1:0] clamp(input logic signed [ACC_WIDTH-1:0] v);
    if (v > ClampHi) return REPORT_MAX;
    if (v < ClampLo) return REPORT_MIN;
    return v[BYTE_W-1:0];
  endfunction

  logic signed [ACC_WIDTH-1:0] acc_x_q, acc_y_q, acc_w_q;
  logic signed [ACC_WIDTH-1:0] acc_x_d, acc_y_d, acc_w_d;
  logic signed [ACC_WIDTH-1:0] sum_x, sum_y, sum_w;
  logic signed [BYTE_W-1:0]    cl_x, cl_y, cl_w;
  logic [BYTE_W-1:0]           sent_btn_q, sent_btn_d;
  logic                        mouse_send;
  logic                        out_valid_q;
  hmra_result_t                result_q, result_d;

  assign pop_o       = !empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  always_comb begin
    sum_x = sat_add(acc_x_q, entry_i.delta_x);
    sum_y = sat_add(acc_y_q, entry_i.delta_y);
    sum_w = sat_add(acc_w_q, entry_i.delta_wheel);
    cl_x  = clamp(sum_x);
    cl_y  = clamp(sum_y);
    cl_w  = clamp(sum_w);

    mouse_send = entry_i.host_ready && !entry_i.kbd_send &&
                 ((sum_x != '0) || (sum_y != '0) || (sum_w != '0) ||
                  (entry_i.buttons != sent_btn_q));

    // Subtract only what goes out; the rest carries over.
    acc_x_d    = mouse_send ? sum_x - ACC_WIDTH'(cl_x) : sum_x;
    acc_y_d    = mouse_send ? sum_y - ACC_WIDTH'(cl_y) : sum_y;
    acc_w_d    = mouse_send ? sum_w - ACC_WIDTH'(cl_w) : sum_w;
    sent_btn_d = mouse_send ? entry_i.buttons : sent_btn_q;

    result_d          = '0;
    result_d.kind     = KIND_NONE;
    result_d.accepted = entry_i.host_ready;
    if (entry_i.kbd_send) begin
      result_d.kind      = KIND_KEYBOARD;
      result_d.modifiers = entry_i.modifiers;
      result_d.keys      = entry_i.keys;
    end else if (mouse_send) begin
      result_d.kind    = KIND_MOUSE;
      result_d.buttons = entry_i.buttons;
      result_d.dx      = cl_x;
      result_d.dy      = cl_y;
      result_d.wheel   = cl_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_w_q     <= '0;
      sent_btn_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        acc_x_q    <= acc_x_d;
        acc_y_q    <= acc_y_d;
        acc_w_q    <= acc_w_d;
        sent_btn_q <= sent_btn_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) result_q <= result_d;
  end

  a_report_needs_host: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.kind != KIND_NONE)) |-> result_q.accepted)
    else $error("report produced while host not ready");

  a_axis_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.kind == KIND_MOUSE)) |->
      ((result_q.dx != 8'sh80) && (result_q.dy != 8'sh80) && (result_q.wheel != 8'sh80)))
    else $error("mouse axis outside report range");

endmodule

// ----- rtl/hid_motion_report_arbiter_top.sv -----
// HID motion report arbiter: top level tying front end, queue and back end.
// Depends on hmra_pkg, hmra_front, hmra_fifo and hmra_back.
`timescale 1ns / 1ps

// Every input transaction is one tick and yields exactly one result transaction.
// The block sustains one tick per clock while the output is not stalled: the
// front end registers keyboard state and decides keyboard reports in the
// accepting cycle, a two-entry queue holds classified ticks, and the back end
// updates the motion accumulators and loads the output register together when
// it pops a tick. An accepted tick passes through the queue and then the output
// register, with the accumulator add, saturate, clamp and subtract path between
// the two. in_stall_o rises only when the queue is full, and a waiting result
// never blocks the back end from taking the next tick once it is consumed.
// Keyboard reports win over mouse reports; mouse axes go out clamped to
// +/-127 and the remainder stays in the saturating accumulators.
module hid_motion_report_arbiter_top import hmra_pkg::*; #(
  parameter int unsigned KEY_SLOTS = 6,
  parameter int unsigned ACC_WIDTH = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [DELTA_W-1:0] delta_x_i,
  input  logic signed [DELTA_W-1:0] delta_y_i,
  input  logic signed [DELTA_W-1:0] delta_wheel_i,
  input  logic [BYTE_W-1:0]         pointer_buttons_i,
  input  logic [BYTE_W-1:0]         modifier_bits_i,
  input  logic [BYTE_W-1:0]         key_slot_0_i,
  input  logic [BYTE_W-1:0]         key_slot_1_i,
  input  logic [BYTE_W-1:0]         key_slot_2_i,
  input  logic [BYTE_W-1:0]         key_slot_3_i,
  input  logic [BYTE_W-1:0]         key_slot_4_i,
  input  logic [BYTE_W-1:0]         key_slot_5_i,
  input  logic                      host_ready_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                report_kind_o,
  output logic                      accepted_o,
  output logic [BYTE_W-1:0]         report_modifiers_o,
  output logic [KEYS_W-1:0]         report_keys_o,
  output logic [BYTE_W-1:0]         report_buttons_o,
  output logic signed [BYTE_W-1:0]  report_dx_o,
  output logic signed [BYTE_W-1:0]  report_dy_o,
  output logic signed [BYTE_W-1:0]  report_wheel_o
);

  logic         push;
  logic         pop;
  logic         full;
  logic         empty;
  hmra_entry_t  front_entry;
  hmra_entry_t  queue_entry;
  hmra_result_t result;
  logic [KEYS_W-1:0] keys_in;

  // Pack the key slots with slot 0 in the lowest byte.
  assign keys_in = {key_slot_5_i, key_slot_4_i, key_slot_3_i,
                    key_slot_2_i, key_slot_1_i, key_slot_0_i};

  // Stall the input only when the queue has no room.
  assign in_stall_o = full;

  hmra_front #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .full_i        (full),
    .delta_x_i     (delta_x_i),
    .delta_y_i     (delta_y_i),
    .delta_wheel_i (delta_wheel_i),
    .buttons_i     (pointer_buttons_i),
    .modifiers_i   (modifier_bits_i),
    .keys_i        (keys_in),
    .host_ready_i  (host_ready_i),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  hmra_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .entry_o (queue_entry)
  );

  hmra_back #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (queue_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  // Break the result transaction out onto its field ports.
  assign report_kind_o      = result.kind;
  assign accepted_o         = result.accepted;
  assign report_modifiers_o = result.modifiers;
  assign report_keys_o      = result.keys;
  assign report_buttons_o   = result.buttons;
  assign report_dx_o        = result.dx;
  assign report_dy_o        = result.dy;
  assign report_wheel_o     = result.wheel;

endmodule
